/* rtl/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared widths, opcodes and transaction types for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam int ENTRIES_DEF = 16;
    localparam int CAP_RESET   = 16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } lkvc_req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
    } lkvc_res_t;

endpackage

/* rtl/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One transaction at a time. A get that misses skips the update pass;
// every other transaction makes two passes over the entry memories at one
// entry per cycle: a scan for the key, a free slot and the oldest entry, then a
// read-modify-write pass over the recency ranks. A finished result sits in
// an output register, so the next transaction is taken while it waits.
// The store is empty after reset; no clearing pass is needed. Write capacity
// only while no transaction is in flight; zero acts as one and values above
// ENTRIES saturate.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0]         capacity,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic signed [lkvc_pkg::DATA_W-1:0] key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] read_value,
    output logic                               evicted
);
    import lkvc_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    lkvc_req_t        req;
    lkvc_res_t        res;
    lkvc_res_t        out_reg;
    logic             out_valid_reg;
    logic             res_valid;
    logic             res_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_W'(CAP_RESET);
        end
        else if (cfg_valid)
        begin
            capacity_reg <= capacity;
        end
    end

    assign req.op    = op;
    assign req.key   = key;
    assign req.value = value;

    lkvc_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output stage: take a new result when empty or draining
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = out_reg.hit;
    assign read_value = out_reg.read_value;
    assign evicted    = out_reg.evicted;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("engine accepted back-to-back transactions");

    a_evict_is_set_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> !hit && read_value == '0)
        else $error("eviction reported on a hit or with read data");

    a_no_result_without_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a transaction in flight");
`endif

endmodule

/* rtl/lkvc_engine.sv */
// ----------------------------------------------------------------------------
// lkvc_engine
// Lookup and recency engine: key/value and recency memories, a scan pass
// that finds the match, the first free slot and the oldest entry, and an
// update pass that rewrites the recency ranks.
// ----------------------------------------------------------------------------
module lkvc_engine #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lkvc_pkg::CAP_W-1:0]    capacity,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  lkvc_pkg::lkvc_req_t           req,
    output logic                          res_valid,
    input  logic                          res_ready,
    output lkvc_pkg::lkvc_res_t           res
);
    import lkvc_pkg::*;

    localparam int IW   = $clog2(ENTRIES);
    localparam int CW   = IW + 1;
    localparam int RW   = IW;
    localparam int KVW  = 2 * DATA_W;
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_UPD    = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    // memories
    logic [KVW-1:0] kv_mem  [ENTRIES];
    logic [RW-1:0]  rec_mem [ENTRIES];
    logic [KVW-1:0] kv_rd_reg;
    logic [RW-1:0]  rec_rd_reg;
    logic           kv_we;
    logic [IW-1:0]  kv_wa;
    logic           rec_we;
    logic [IW-1:0]  rec_wa;
    logic [RW-1:0]  rec_wd;
    logic [IW-1:0]  rd_addr;

    // control state
    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic               found_reg, found_next;
    logic               free_found_reg, free_found_next;
    logic               old_any_reg, old_any_next;
    logic               age_all_reg, age_all_next;

    // payload state
    lkvc_req_t          req_q_reg, req_q_next;
    lkvc_res_t          res_reg, res_next;
    logic [IW-1:0]      match_idx_reg, match_idx_next;
    logic [DATA_W-1:0]  hit_val_reg, hit_val_next;
    logic [RW-1:0]      hit_rec_reg, hit_rec_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    logic [IW-1:0]      old_idx_reg, old_idx_next;
    logic [RW-1:0]      old_rec_reg, old_rec_next;
    logic [IW-1:0]      tgt_reg, tgt_next;
    logic [RW-1:0]      lim_reg, lim_next;

    logic [CW-1:0]      cnt_m1;
    logic [IW-1:0]      chk_idx;
    logic               pass_last;
    logic [DATA_W-1:0]  rd_key;
    logic [DATA_W-1:0]  rd_val;
    logic [CMPW-1:0]    cap_ext;
    logic [CMPW-1:0]    eff_cap;
    logic               has_room;

    assign rd_addr   = cnt_reg[IW-1:0];
    assign cnt_m1    = cnt_reg - CW'(1);
    assign chk_idx   = cnt_m1[IW-1:0];
    assign pass_last = (cnt_reg == CW'(ENTRIES));
    assign rd_key    = kv_rd_reg[KVW-1:DATA_W];
    assign rd_val    = kv_rd_reg[DATA_W-1:0];
    assign kv_wa     = tgt_next;

    // capacity zero acts as one, above the store size saturates
    assign cap_ext  = CMPW'(capacity);
    assign eff_cap  = (cap_ext == '0) ? CMPW'(1)
                    : (cap_ext > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_ext;
    assign has_room = (CMPW'(fill_reg) < eff_cap);

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    always_ff @(posedge clk)
    begin
        if (kv_we)
        begin
            kv_mem[kv_wa] <= {req_q_reg.key, req_q_reg.value};
        end
        kv_rd_reg <= kv_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_wa] <= rec_wd;
        end
        rec_rd_reg <= rec_mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        valid_next      = valid_reg;
        fill_next       = fill_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        old_any_next    = old_any_reg;
        age_all_next    = age_all_reg;
        req_q_next      = req_q_reg;
        res_next        = res_reg;
        match_idx_next  = match_idx_reg;
        hit_val_next    = hit_val_reg;
        hit_rec_next    = hit_rec_reg;
        free_idx_next   = free_idx_reg;
        old_idx_next    = old_idx_reg;
        old_rec_next    = old_rec_reg;
        tgt_next        = tgt_reg;
        lim_next        = lim_reg;
        kv_we           = 1'b0;
        rec_we          = 1'b0;
        rec_wa          = chk_idx;
        rec_wd          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_q_next      = req;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    old_any_next    = 1'b0;
                    cnt_next        = '0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // read data for entry cnt-1 is on the memory outputs
                if (cnt_reg != '0)
                begin
                    if (valid_reg[chk_idx] && !found_reg &&
                        rd_key == req_q_reg.key)
                    begin
                        found_next     = 1'b1;
                        match_idx_next = chk_idx;
                        hit_val_next   = rd_val;
                        hit_rec_next   = rec_rd_reg;
                    end
                    if (!valid_reg[chk_idx] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx;
                    end
                    if (valid_reg[chk_idx] && (!old_any_reg || rec_rd_reg > old_rec_reg))
                    begin
                        old_any_next = 1'b1;
                        old_idx_next = chk_idx;
                        old_rec_next = rec_rd_reg;
                    end
                end
                cnt_next = cnt_reg + CW'(1);
                if (pass_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                res_next.hit        = found_reg;
                res_next.evicted    = 1'b0;
                res_next.read_value = '0;
                cnt_next            = '0;
                state_next          = ST_UPD;
                if (found_reg)
                begin
                    tgt_next     = match_idx_reg;
                    lim_next     = hit_rec_reg;
                    age_all_next = 1'b0;
                    if (req_q_reg.op == OP_GET)
                    begin
                        res_next.read_value = hit_val_reg;
                    end
                    else
                    begin
                        kv_we = 1'b1;
                    end
                end
                else if (req_q_reg.op == OP_GET)
                begin
                    // miss on get: nothing changes
                    res_next.read_value = '1;
                    state_next          = ST_DONE;
                end
                else
                begin
                    age_all_next = 1'b1;
                    lim_next     = '0;
                    kv_we        = 1'b1;
                    if (has_room)
                    begin
                        tgt_next  = free_idx_reg;
                        fill_next = fill_reg + CW'(1);
                    end
                    else
                    begin
                        tgt_next         = old_idx_reg;
                        res_next.evicted = 1'b1;
                    end
                    valid_next[tgt_next] = 1'b1;
                end
            end

            ST_UPD:
            begin
                // rewrite entry cnt-1 while entry cnt is being read
                if (cnt_reg != '0)
                begin
                    if (chk_idx == tgt_reg)
                    begin
                        rec_we = 1'b1;
                        rec_wd = '0;
                    end
                    else if (valid_reg[chk_idx] && (age_all_reg || rec_rd_reg < lim_reg))
                    begin
                        rec_we = 1'b1;
                        rec_wd = rec_rd_reg + RW'(1);
                    end
                end
                cnt_next = cnt_reg + CW'(1);
                if (pass_last)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            valid_reg      <= '0;
            fill_reg       <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            old_any_reg    <= 1'b0;
            age_all_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            valid_reg      <= valid_next;
            fill_reg       <= fill_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            old_any_reg    <= old_any_next;
            age_all_reg    <= age_all_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_q_reg     <= req_q_next;
        res_reg       <= res_next;
        match_idx_reg <= match_idx_next;
        hit_val_reg   <= hit_val_next;
        hit_rec_reg   <= hit_rec_next;
        free_idx_reg  <= free_idx_next;
        old_idx_reg   <= old_idx_next;
        old_rec_reg   <= old_rec_next;
        tgt_reg       <= tgt_next;
        lim_reg       <= lim_next;
    end

endmodule

/* test/lru_key_value_cache_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Self-checking bench for the LRU key-value cache. A short table of directed
// gets, sets and capacity writes runs first. Random phases follow, each under
// its own capacity and key pool. Fixed rows are checked against the table,
// all other results against a local LRU model; both channels idle at random.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
    import lkvc_pkg::*;

    localparam int ENTRIES     = ENTRIES_DEF;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 160;
    localparam int HOLD_OFF    = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int PRINT_LIMIT = 50;

    localparam logic [DATA_W-1:0] READ_MISS = '1;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic               op;
        logic [DATA_W-1:0]  key;
        logic [DATA_W-1:0]  value;
        logic [CAP_W-1:0]   cap;
        logic               fixed;
        lkvc_res_t          want;
    } stim_row_t;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     cfg_valid  = 1'b0;
    logic                     cfg_ready;
    logic [CAP_W-1:0]         capacity   = CAP_W'(CAP_RESET);
    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    logic                     op         = OP_GET;
    logic signed [DATA_W-1:0] key        = '0;
    logic signed [DATA_W-1:0] value      = '0;
    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;

    // Model of the store
    bit                slot_used [ENTRIES];
    logic [DATA_W-1:0] slot_key  [ENTRIES];
    logic [DATA_W-1:0] slot_data [ENTRIES];
    int unsigned       slot_age  [ENTRIES];
    int unsigned       used_count = 0;
    logic [CAP_W-1:0]  cur_cap    = CAP_W'(CAP_RESET);

    lkvc_res_t pending_lookups [$];
    stim_row_t dir_rows [$];

    int mismatches   = 0;
    int results_seen = 0;
    bit tx_gaps      = 1'b1;
    bit offering     = 1'b0;
    bit hold_off_req = 1'b0;

    lru_key_value_cache u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .capacity   (capacity),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .key        (key),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .read_value (read_value),
        .evicted    (evicted)
    );

    always #4 clk = ~clk;

    // Make slot the youngest; valid entries younger than limit age by one.
    function automatic void promote(int unsigned slot, int unsigned limit);
        int i;
        for (i = 0; i < ENTRIES; i++)
        begin
            if (slot_used[i] && i != slot && slot_age[i] < limit)
                slot_age[i]++;
        end
        slot_age[slot] = 0;
    endfunction

    function automatic lkvc_res_t lru_access(logic acc_op, logic [DATA_W-1:0] acc_key,
                                             logic [DATA_W-1:0] acc_val);
        lkvc_res_t   r;
        int          i;
        int          slot;
        bit          found;
        bit          seen;
        int unsigned cap_eff;
        int unsigned oldest;
        r      = '0;
        slot   = 0;
        found  = 1'b0;
        seen   = 1'b0;
        oldest = 0;
        for (i = 0; i < ENTRIES; i++)
        begin
            if (!found && slot_used[i] && slot_key[i] == acc_key)
            begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            if (acc_op == OP_GET)
                r.read_value = slot_data[slot];
            else
                slot_data[slot] = acc_val;
            promote(slot, slot_age[slot]);
        end
        else if (acc_op == OP_GET)
        begin
            r.read_value = READ_MISS;
        end
        else
        begin
            cap_eff = (cur_cap == 0) ? 1 : (cur_cap > ENTRIES) ? ENTRIES : cur_cap;
            if (used_count < cap_eff)
            begin
                // take the lowest free slot
                for (i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (!slot_used[i])
                        slot = i;
                end
                used_count++;
            end
            else
            begin
                for (i = 0; i < ENTRIES; i++)
                begin
                    if (slot_used[i] && (!seen || slot_age[i] > oldest))
                    begin
                        oldest = slot_age[i];
                        slot   = i;
                        seen   = 1'b1;
                    end
                end
                r.evicted = 1'b1;
            end
            slot_used[slot] = 1'b1;
            slot_key[slot]  = acc_key;
            slot_data[slot] = acc_val;
            promote(slot, 32'hFFFF_FFFF);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
    endtask

    function automatic void add_item(logic r_op, logic [DATA_W-1:0] r_key,
                                     logic [DATA_W-1:0] r_val, bit fixed = 1'b0,
                                     logic r_hit = 1'b0, logic [DATA_W-1:0] r_rd = '0,
                                     logic r_ev = 1'b0);
        stim_row_t row;
        row                 = '0;
        row.kind            = ROW_ITEM;
        row.op              = r_op;
        row.key             = r_key;
        row.value           = r_val;
        row.fixed           = fixed;
        row.want.hit        = r_hit;
        row.want.read_value = r_rd;
        row.want.evicted    = r_ev;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [CAP_W-1:0] c);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_CFG;
        row.cap  = c;
        dir_rows.push_back(row);
    endfunction

    task automatic drop_offer();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        drop_offer();
        while (pending_lookups.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_lookup(logic s_op, logic [DATA_W-1:0] s_key, logic [DATA_W-1:0] s_val,
                               bit fixed, lkvc_res_t want);
        int        gap;
        lkvc_res_t pred;
        gap = tx_gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            if (offering)
            begin
                in_valid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= s_op;
        key      <= s_key;
        value    <= s_val;
        offering = 1'b1;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        pred = lru_access(s_op, s_key, s_val);
        pending_lookups.push_back(fixed ? want : pred);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] c);
        drain_results();
        cfg_valid <= 1'b1;
        capacity  <= c;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        cur_cap = c;
        @(posedge clk);
    endtask

    initial
    begin : result_side
        int        rx_wait;
        bit        rx_gaps;
        lkvc_res_t want;
        rx_wait = 0;
        rx_gaps = 1'b1;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_lookups.size() == 0)
                begin
                    report_mismatch("result with nothing pending, read_value", read_value, '0);
                end
                else
                begin
                    want = pending_lookups.pop_front();
                    if (hit !== want.hit)
                        report_mismatch("hit", DATA_W'(hit), DATA_W'(want.hit));
                    if (read_value !== want.read_value)
                        report_mismatch("read_value", read_value, want.read_value);
                    if (evicted !== want.evicted)
                        report_mismatch("evicted", DATA_W'(evicted), DATA_W'(want.evicted));
                end
                if (results_seen % 32 == 0)
                    rx_gaps = ($urandom_range(0, 2) != 0);
                rx_wait = rx_gaps ? $urandom_range(0, 15) : 0;
            end
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rx_wait      = HOLD_OFF;
            end
            if (rx_wait > 0)
            begin
                out_ready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        int                r;
        int                p;
        int                n;
        int                pool_len;
        int                phase_caps [PHASES];
        logic [CAP_W-1:0]  next_cap;
        logic [DATA_W-1:0] key_pool [$];
        logic [DATA_W-1:0] k;
        logic              o;

        phase_caps = '{1, 0, 31, 17, 2, 3, 16, -1, 4, 8, -1, 16};

        // Reset state: empty store, capacity sixteen
        add_item(OP_GET, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b0, READ_MISS, 1'b0);
        add_item(OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, READ_MISS, 1'b0);
        add_item(OP_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 32'h0, 1'b0);
        add_item(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000, 1'b0);
        add_item(OP_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0);
        // overwrite of a present key
        add_item(OP_SET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, 1'b0);
        add_item(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
        add_item(OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0);
        add_item(OP_SET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 1'b0);
        add_item(OP_GET, 32'hFFFF_FFFF, 32'h5555_5555);
        // capacity below the number of entries in use
        add_cfg(5'd2);
        add_item(OP_SET, 32'h0000_0001, 32'h5555_5555);
        add_item(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        add_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
        add_item(OP_SET, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
        // zero acts as one
        add_cfg(5'd0);
        add_item(OP_SET, 32'h0000_0000, 32'h1234_5678);
        add_item(OP_GET, 32'h0000_0000, 32'h0000_0000);
        add_item(OP_SET, 32'h0000_0000, 32'h8765_4321);
        // above the entry count saturates
        add_cfg(5'd31);
        add_item(OP_SET, 32'h0000_0002, 32'hDEAD_BEEF);
        add_item(OP_SET, 32'h0000_0003, 32'h0BAD_F00D);
        add_item(OP_GET, 32'h0000_0001, 32'h0000_0000);
        add_cfg(5'd16);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < dir_rows.size(); r++)
        begin
            if (dir_rows[r].kind == ROW_CFG)
                write_capacity(dir_rows[r].cap);
            else
                send_lookup(dir_rows[r].op, dir_rows[r].key, dir_rows[r].value,
                            dir_rows[r].fixed, dir_rows[r].want);
        end

        for (p = 0; p < PHASES; p++)
        begin
            next_cap = (phase_caps[p] < 0) ? CAP_W'($urandom_range(0, 31)) : CAP_W'(phase_caps[p]);
            write_capacity(next_cap);
            // a pool a little larger than the live set gives both hits and evictions
            pool_len = ((next_cap == 0) ? 1 : (next_cap > ENTRIES) ? ENTRIES : next_cap)
                       + $urandom_range(1, 6);
            key_pool.delete();
            repeat (pool_len) key_pool.push_back($urandom());
            tx_gaps = p[0];
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 32 == 31)
                    tx_gaps = ($urandom_range(0, 2) != 0);
                if (p == 2 && n == 60)
                    hold_off_req = 1'b1;
                if (p == 5 && n == 80)
                    drain_results();
                o = ($urandom_range(0, 99) < 45) ? OP_SET : OP_GET;
                k = ($urandom_range(0, 9) == 0) ? $urandom()
                                                : key_pool[$urandom_range(0, pool_len - 1)];
                send_lookup(o, k, $urandom(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (2 * ENTRIES + 8) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
